// ===== rtl/core/gbnws_pkg.sv =====
package gbnws_pkg;

  // Largest window the growth step may reach, whatever window_cap says
  localparam int WINDOW_LIMIT = 32;

  // Input modes
  localparam logic [1:0] MODE_START   = 2'd0;
  localparam logic [1:0] MODE_ACK     = 2'd1;
  localparam logic [1:0] MODE_TIMEOUT = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_TX      = 3'd0;
  localparam logic [2:0] KIND_ACK     = 3'd1;
  localparam logic [2:0] KIND_IGNORED = 3'd2;
  localparam logic [2:0] KIND_DONE    = 3'd3;
  localparam logic [2:0] KIND_TIMEOUT = 3'd4;

  // Configuration register indexes
  localparam logic CFG_INITIAL_SEQUENCE = 1'b0;
  localparam logic CFG_WINDOW_CAP       = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] chunk_total;
    logic        ack_is_data_ack;
    logic [7:0]  ack_sequence;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tx_sequence;
    logic [15:0] tx_chunk;
    logic [5:0]  window_now;
    logic        last;
  } out_item_t;

  // What the held item does to the sender state
  typedef enum logic [2:0] {
    ACT_IGNORE,
    ACT_EMPTY,
    ACT_START,
    ACT_ACK_PART,
    ACT_ACK_DONE,
    ACT_ACK_NEXT,
    ACT_TIMEOUT
  } act_t;

  typedef struct packed {
    logic latch;   // capture the accepted item
    logic apply;   // apply the item's state update, emit its lead result if it has one
    logic send;    // emit one transmit of the round
  } cmd_t;

  typedef struct packed {
    act_t act;        // decoded action of the held item
    logic out_free;   // output register can take a result this cycle
    logic round_end;  // transmit going out now closes the round
  } status_t;

endpackage

// ===== rtl/core/go_back_n_window_sender.sv =====
// Go-back-N sender controller with an adaptive window. One item is worked at
// a time: after it is accepted, it is decoded against the sender state, then
// results leave one per cycle, unless the output stalls, through the output
// register. An item gives either a single result (ack accepted, ignored, done)
// or a round of n transmits, n being at most the window; a timeout gives its
// notice, loaded when the item is decoded, ahead of its round. A new item is
// accepted at the edge after the last result of the previous one is loaded
// into the output register.
// Configuration writes are always ready and should be issued only while the
// block is idle.
module go_back_n_window_sender (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gbnws_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gbnws_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_data
);

  gbnws_pkg::cmd_t    cmd;
  gbnws_pkg::status_t status;

  assign cfg_ready = 1'b1;

  gbnws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  gbnws_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/gbnws_ctrl.sv =====
module gbnws_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  gbnws_pkg::status_t status,
  output gbnws_pkg::cmd_t    cmd,
  output logic              in_stall
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_SEND
  } state_t;

  state_t state;
  state_t state_next;
  logic   opens_round;

  // Actions that are followed by a round of transmits
  assign opens_round = (status.act == gbnws_pkg::ACT_START) ||
                       (status.act == gbnws_pkg::ACT_ACK_NEXT) ||
                       (status.act == gbnws_pkg::ACT_TIMEOUT);

  assign in_stall = (state != S_IDLE);

  // Commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (status.out_free) begin
          cmd.apply  = 1'b1;
          state_next = opens_round ? S_SEND : S_IDLE;
        end
      end
      S_SEND: begin
        if (status.out_free) begin
          cmd.send = 1'b1;
          if (status.round_end) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/gbnws_dp.sv =====
module gbnws_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_data,
  input  gbnws_pkg::in_item_t  in_data,
  input  logic                 out_stall,
  input  gbnws_pkg::cmd_t      cmd,
  output gbnws_pkg::status_t   status,
  output logic                 out_valid,
  output gbnws_pkg::out_item_t out_data
);

  // Configuration
  logic [7:0]  initial_sequence;
  logic [5:0]  window_cap;

  // Sender state
  logic        busy;
  logic [5:0]  window_len;
  logic [7:0]  next_sequence;
  logic [15:0] chunks_sent;
  logic [15:0] chunks_in_message;
  logic [5:0]  round_packets;
  logic [5:0]  round_acks;
  logic [5:0]  round_count;

  // Held item
  gbnws_pkg::in_item_t item;

  logic [5:0]  cap;
  logic [5:0]  grown;
  logic [5:0]  halved;
  logic [7:0]  want;
  logic [6:0]  acks_plus;
  logic        ack_match;
  logic        out_free;
  logic [2:0]  lead_kind;
  logic [5:0]  lead_window;
  logic        lead_last;
  gbnws_pkg::act_t act;

  // Effective cap: zero acts as one, never above the limit
  always_comb begin
    if (window_cap == 6'd0) begin
      cap = 6'd1;
    end else if (7'(window_cap) > 7'(gbnws_pkg::WINDOW_LIMIT)) begin
      cap = 6'(gbnws_pkg::WINDOW_LIMIT);
    end else begin
      cap = window_cap;
    end
  end

  assign grown  = ((7'(window_len) + 7'd1) < 7'(cap)) ? (window_len + 6'd1) : cap;
  assign halved = (window_len[5:1] > 5'd1) ? {1'b0, window_len[5:1]} : 6'd1;

  // Next in-order ack expected in the round
  assign want      = next_sequence - {2'b00, round_packets} + {2'b00, round_acks};
  assign acks_plus = 7'(round_acks) + 7'd1;
  assign ack_match = item.ack_is_data_ack && (item.ack_sequence == want);

  // Decode the held item
  always_comb begin
    act = gbnws_pkg::ACT_IGNORE;
    if (item.mode == gbnws_pkg::MODE_START && !busy) begin
      act = (item.chunk_total == 16'd0) ? gbnws_pkg::ACT_EMPTY : gbnws_pkg::ACT_START;
    end else if (item.mode == gbnws_pkg::MODE_ACK && busy && ack_match) begin
      if (acks_plus < 7'(round_packets)) begin
        act = gbnws_pkg::ACT_ACK_PART;
      end else if (chunks_sent >= chunks_in_message) begin
        act = gbnws_pkg::ACT_ACK_DONE;
      end else begin
        act = gbnws_pkg::ACT_ACK_NEXT;
      end
    end else if (item.mode == gbnws_pkg::MODE_TIMEOUT && busy) begin
      act = gbnws_pkg::ACT_TIMEOUT;
    end
  end

  // Lead result of the held item
  always_comb begin
    lead_kind   = gbnws_pkg::KIND_IGNORED;
    lead_window = window_len;
    lead_last   = 1'b1;
    case (act)
      gbnws_pkg::ACT_EMPTY: begin
        lead_kind   = gbnws_pkg::KIND_DONE;
        lead_window = 6'd1;
      end
      gbnws_pkg::ACT_ACK_PART: begin
        lead_kind = gbnws_pkg::KIND_ACK;
      end
      gbnws_pkg::ACT_ACK_DONE: begin
        lead_kind   = gbnws_pkg::KIND_DONE;
        lead_window = grown;
      end
      gbnws_pkg::ACT_TIMEOUT: begin
        lead_kind   = gbnws_pkg::KIND_TIMEOUT;
        lead_window = halved;
        lead_last   = 1'b0;
      end
      default: ;
    endcase
  end

  assign out_free         = !out_valid || !out_stall;
  assign status.act       = act;
  assign status.out_free  = out_free;
  assign status.round_end = ((7'(round_count) + 7'd1) == 7'(window_len)) ||
                            ((17'(chunks_sent) + 17'd1) == 17'(chunks_in_message));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_sequence <= 8'd0;
      window_cap       <= 6'd8;
    end else if (cfg_valid) begin
      case (cfg_index)
        gbnws_pkg::CFG_INITIAL_SEQUENCE: initial_sequence <= cfg_data;
        gbnws_pkg::CFG_WINDOW_CAP:       window_cap       <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Held item
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item <= in_data;
    end
  end

  // Sender state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      busy              <= 1'b0;
      window_len        <= 6'd1;
      next_sequence     <= 8'd0;
      chunks_sent       <= 16'd0;
      chunks_in_message <= 16'd0;
      round_packets     <= 6'd0;
      round_acks        <= 6'd0;
      round_count       <= 6'd0;
    end else if (cmd.apply) begin
      case (act)
        gbnws_pkg::ACT_EMPTY, gbnws_pkg::ACT_START: begin
          busy              <= (act == gbnws_pkg::ACT_START);
          window_len        <= 6'd1;
          next_sequence     <= initial_sequence;
          chunks_sent       <= 16'd0;
          chunks_in_message <= item.chunk_total;
          round_packets     <= 6'd0;
          round_acks        <= 6'd0;
          round_count       <= 6'd0;
        end
        gbnws_pkg::ACT_ACK_PART: begin
          round_acks <= acks_plus[5:0];
        end
        gbnws_pkg::ACT_ACK_DONE: begin
          window_len    <= grown;
          busy          <= 1'b0;
          round_packets <= 6'd0;
          round_acks    <= 6'd0;
        end
        gbnws_pkg::ACT_ACK_NEXT: begin
          window_len  <= grown;
          round_count <= 6'd0;
        end
        gbnws_pkg::ACT_TIMEOUT: begin
          window_len    <= halved;
          chunks_sent   <= chunks_sent - {10'd0, round_packets};
          next_sequence <= next_sequence - {2'b00, round_packets};
          round_acks    <= 6'd0;
          round_count   <= 6'd0;
        end
        default: ;
      endcase
    end else if (cmd.send) begin
      next_sequence <= next_sequence + 8'd1;
      chunks_sent   <= chunks_sent + 16'd1;
      round_count   <= round_count + 6'd1;
      if (status.round_end) begin
        round_packets <= round_count + 6'd1;
        round_acks    <= 6'd0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.apply) begin
      out_valid <= (act != gbnws_pkg::ACT_START) && (act != gbnws_pkg::ACT_ACK_NEXT);
    end else if (cmd.send) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_data.kind        <= lead_kind;
      out_data.tx_sequence <= 8'd0;
      out_data.tx_chunk    <= 16'd0;
      out_data.window_now  <= lead_window;
      out_data.last        <= lead_last;
    end else if (cmd.send) begin
      out_data.kind        <= gbnws_pkg::KIND_TX;
      out_data.tx_sequence <= next_sequence;
      out_data.tx_chunk    <= chunks_sent;
      out_data.window_now  <= window_len;
      out_data.last        <= status.round_end;
    end
  end

endmodule

// ===== rtl/core/gbnws_checker.sv =====
module gbnws_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input gbnws_pkg::out_item_t out_data
);

  // One item at a time: an accepted item blocks the input next cycle
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not blocked after accepting an item");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // Only transmit results carry sequence and chunk
  a_tx_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind != gbnws_pkg::KIND_TX) |->
      (out_data.tx_sequence == 8'd0 && out_data.tx_chunk == 16'd0))
    else $error("non-transmit result carries transmit fields");

  // Single-result kinds always close their item
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.kind == gbnws_pkg::KIND_ACK ||
                   out_data.kind == gbnws_pkg::KIND_IGNORED ||
                   out_data.kind == gbnws_pkg::KIND_DONE)) |-> out_data.last)
    else $error("single result without last");

  // Window never reads zero
  a_window: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.window_now != 6'd0))
    else $error("zero window reported");

endmodule

bind go_back_n_window_sender gbnws_checker u_gbnws_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== test/tb_go_back_n_window_sender.sv =====
module tb_go_back_n_window_sender;

  // Mode value with no meaning to the block
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int END_CYCLES     = 12;

  typedef struct packed {
    logic                 is_write;
    logic                 reg_index;
    logic [7:0]           reg_value;
    gbnws_pkg::in_item_t  item;
    logic                 typed;
    gbnws_pkg::out_item_t result;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  gbnws_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  gbnws_pkg::out_item_t out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic                 cfg_index;
  logic [7:0]           cfg_data;

  go_back_n_window_sender dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sender state as the block should hold it
  bit          tx_busy      = 1'b0;
  logic [5:0]  cur_window   = 6'd1;
  logic [7:0]  next_seq     = 8'd0;
  logic [15:0] chunks_sent  = 16'd0;
  logic [15:0] chunks_total = 16'd0;
  logic [5:0]  round_sent   = 6'd0;
  logic [5:0]  round_acked  = 6'd0;
  logic [7:0]  first_seq    = 8'd0;
  logic [5:0]  window_cap   = 6'd8;

  gbnws_pkg::out_item_t item_results[$];
  gbnws_pkg::out_item_t results_due[$];
  plan_row_t            directed_plan[$];

  int  src_idle    = 21;
  int  sink_idle   = 51;
  bit  hold_armed  = 1'b0;
  bit  sink_hold   = 1'b0;
  int  mismatches  = 0;
  int  quiet_cycles = 0;

  task automatic report_mismatch(input string what);
    if (mismatches < 100) $display("%0t: mismatch, %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  function automatic void emit(input logic [2:0] kind, input logic [7:0] seq,
                               input logic [15:0] chunk, input logic last);
    gbnws_pkg::out_item_t r;
    r.kind        = kind;
    r.tx_sequence = seq;
    r.tx_chunk    = chunk;
    r.window_now  = cur_window;
    r.last        = last;
    item_results.push_back(r);
  endfunction

  function automatic logic [7:0] next_wanted_ack();
    return next_seq - 8'(round_sent) + 8'(round_acked);
  endfunction

  // One round: up to a window of transmits, the final one flagged last
  function automatic void send_round();
    int n;
    n = 0;
    while (n < cur_window && chunks_sent < chunks_total) begin
      emit(gbnws_pkg::KIND_TX, next_seq, chunks_sent,
           n + 1 == cur_window || chunks_sent + 1 == chunks_total);
      next_seq    = next_seq + 8'd1;
      chunks_sent = chunks_sent + 16'd1;
      n++;
    end
    round_sent  = 6'(n);
    round_acked = '0;
  endfunction

  // Updates the sender state for one item and fills item_results;
  // returns 1 when the block should ignore the item
  function automatic bit advance_sender(input gbnws_pkg::in_item_t it);
    int cap;
    item_results.delete();
    if (it.mode == gbnws_pkg::MODE_START && !tx_busy) begin
      chunks_total = it.chunk_total;
      chunks_sent  = '0;
      cur_window   = 6'd1;
      next_seq     = first_seq;
      round_sent   = '0;
      round_acked  = '0;
      if (it.chunk_total == 16'd0) begin
        emit(gbnws_pkg::KIND_DONE, 8'd0, 16'd0, 1'b1);
        return 1'b0;
      end
      tx_busy = 1'b1;
      send_round();
      return 1'b0;
    end
    if (it.mode == gbnws_pkg::MODE_ACK && tx_busy) begin
      if (!it.ack_is_data_ack || it.ack_sequence != next_wanted_ack()) begin
        emit(gbnws_pkg::KIND_IGNORED, 8'd0, 16'd0, 1'b1);
        return 1'b1;
      end
      round_acked = round_acked + 6'd1;
      if (round_acked < round_sent) begin
        emit(gbnws_pkg::KIND_ACK, 8'd0, 16'd0, 1'b1);
        return 1'b0;
      end
      // round complete: additive growth up to the effective cap
      cap = (window_cap == 6'd0) ? 1 : int'(window_cap);
      if (cap > gbnws_pkg::WINDOW_LIMIT) cap = gbnws_pkg::WINDOW_LIMIT;
      cur_window = (int'(cur_window) + 1 < cap) ? cur_window + 6'd1 : 6'(cap);
      if (chunks_sent >= chunks_total) begin
        tx_busy     = 1'b0;
        round_sent  = '0;
        round_acked = '0;
        emit(gbnws_pkg::KIND_DONE, 8'd0, 16'd0, 1'b1);
        return 1'b0;
      end
      send_round();
      return 1'b0;
    end
    if (it.mode == gbnws_pkg::MODE_TIMEOUT && tx_busy) begin
      cur_window  = (cur_window / 2 > 1) ? cur_window / 2 : 6'd1;
      chunks_sent = chunks_sent - round_sent;
      next_seq    = next_seq - round_sent;
      round_acked = '0;
      emit(gbnws_pkg::KIND_TIMEOUT, 8'd0, 16'd0, 1'b0);
      send_round();
      return 1'b0;
    end
    emit(gbnws_pkg::KIND_IGNORED, 8'd0, 16'd0, 1'b1);
    return 1'b1;
  endfunction

  function automatic gbnws_pkg::in_item_t good_ack();
    gbnws_pkg::in_item_t it;
    it.mode            = gbnws_pkg::MODE_ACK;
    it.chunk_total     = 16'($urandom);
    it.ack_is_data_ack = 1'b1;
    it.ack_sequence    = next_wanted_ack();
    return it;
  endfunction

  // Mostly well-formed traffic: starts when idle, in-order acks when busy,
  // with timeouts, stale or out-of-order acks and junk mixed in
  function automatic gbnws_pkg::in_item_t random_item();
    gbnws_pkg::in_item_t it;
    int pick;
    it.mode            = 2'($urandom);
    it.chunk_total     = 16'($urandom);
    it.ack_is_data_ack = 1'($urandom);
    it.ack_sequence    = 8'($urandom);
    pick = $urandom_range(99);
    if (!tx_busy) begin
      if (pick < 85) begin
        it.mode = gbnws_pkg::MODE_START;
        pick = $urandom_range(99);
        if (pick < 5) it.chunk_total = 16'd0;
        else if (pick < 15) it.chunk_total = 16'($urandom_range(60, 13));
        else it.chunk_total = 16'($urandom_range(12, 1));
      end else if (it.mode == gbnws_pkg::MODE_START) begin
        // junk only; a random length would lock up a long transfer
        it.mode = gbnws_pkg::MODE_ACK;
      end
    end else if (pick < 72) begin
      it = good_ack();
    end else if (pick < 80) begin
      it.mode = gbnws_pkg::MODE_TIMEOUT;
    end else if (pick < 88) begin
      it.mode            = gbnws_pkg::MODE_ACK;
      it.ack_is_data_ack = 1'b1;
      it.ack_sequence    = next_wanted_ack() + 8'($urandom_range(255, 1));
    end
    return it;
  endfunction

  function automatic plan_row_t item_row(input logic [1:0] mode, input logic [15:0] total,
                                         input logic dack, input logic [7:0] seq);
    plan_row_t r;
    r = '0;
    r.item = {mode, total, dack, seq};
    return r;
  endfunction

  // Row whose single result is known on sight; sequence and chunk are zero
  function automatic plan_row_t typed_row(input logic [1:0] mode, input logic [15:0] total,
                                          input logic dack, input logic [7:0] seq,
                                          input logic [2:0] kind, input logic [5:0] win);
    plan_row_t r;
    r = item_row(mode, total, dack, seq);
    r.typed  = 1'b1;
    r.result = {kind, 8'd0, 16'd0, win, 1'b1};
    return r;
  endfunction

  function automatic plan_row_t write_row(input logic idx, input logic [7:0] val);
    plan_row_t r;
    r = '0;
    r.is_write  = 1'b1;
    r.reg_index = idx;
    r.reg_value = val;
    return r;
  endfunction

  // Offer one item with a random gap ahead; predict once it is taken
  task automatic offer_item(input gbnws_pkg::in_item_t it, input bit typed,
                            input gbnws_pkg::out_item_t typed_result, output bit ignored);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ignored = advance_sender(it);
    if (typed) results_due.push_back(typed_result);
    else foreach (item_results[i]) results_due.push_back(item_results[i]);
  endtask

  task automatic settle(input int extra);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [7:0] val);
    settle(SETTLE_CYCLES);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == gbnws_pkg::CFG_INITIAL_SEQUENCE) first_seq = val;
    else window_cap = val[5:0];
  endtask

  // Random traffic until enough items have had an effect, then ack the
  // open transfer to its end
  task automatic run_traffic(input int items);
    int counted;
    bit ignored;
    counted = 0;
    while (counted < items) begin
      offer_item(random_item(), 1'b0, '0, ignored);
      if (!ignored) counted++;
    end
    while (tx_busy) offer_item(good_ack(), 1'b0, '0, ignored);
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    out_stall <= sink_hold || ($urandom_range(99) < sink_idle);
  end

  // One long receiver hold-off so the block backs up into its input
  initial begin : receiver_hold
    wait (hold_armed);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  // Result checking against the oldest expectation
  always @(posedge clk) begin : check_results
    gbnws_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result %p with none expected", out_data));
      end else begin
        want = results_due.pop_front();
        check_field("kind", 16'(out_data.kind), 16'(want.kind));
        check_field("tx_sequence", 16'(out_data.tx_sequence), 16'(want.tx_sequence));
        check_field("tx_chunk", out_data.tx_chunk, want.tx_chunk);
        check_field("window_now", 16'(out_data.window_now), 16'(want.window_now));
        check_field("last", 16'(out_data.last), 16'(want.last));
      end
    end
  end

  // Watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, results_due.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    bit ignored;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data  = 8'd0;

    directed_plan = '{
      // idle block: acks, timeouts and the unused mode are ignored
      typed_row(gbnws_pkg::MODE_ACK, 16'd0, 1'b1, 8'h00, gbnws_pkg::KIND_IGNORED, 6'd1),
      typed_row(gbnws_pkg::MODE_TIMEOUT, 16'd0, 1'b0, 8'h00, gbnws_pkg::KIND_IGNORED, 6'd1),
      typed_row(MODE_UNUSED, 16'hFFFF, 1'b1, 8'hFF, gbnws_pkg::KIND_IGNORED, 6'd1),
      // empty message finishes at once
      typed_row(gbnws_pkg::MODE_START, 16'd0, 1'b0, 8'h00, gbnws_pkg::KIND_DONE, 6'd1),
      // top sequence number, zero cap acting as one
      write_row(gbnws_pkg::CFG_INITIAL_SEQUENCE, 8'hFF),
      write_row(gbnws_pkg::CFG_WINDOW_CAP, 8'd0),
      item_row(gbnws_pkg::MODE_START, 16'd3, 1'b0, 8'h00),
      typed_row(gbnws_pkg::MODE_START, 16'hFFFF, 1'b1, 8'hFF, gbnws_pkg::KIND_IGNORED, 6'd1),
      item_row(gbnws_pkg::MODE_ACK, 16'd0, 1'b0, 8'hFF),     // right number, not a data ack
      item_row(gbnws_pkg::MODE_ACK, 16'd0, 1'b1, 8'h00),     // data ack, out of order
      item_row(gbnws_pkg::MODE_ACK, 16'd0, 1'b1, 8'hFF),     // closes round, sequence wraps
      item_row(gbnws_pkg::MODE_TIMEOUT, 16'd0, 1'b0, 8'h00),
      item_row(gbnws_pkg::MODE_ACK, 16'd0, 1'b1, 8'h00),
      item_row(gbnws_pkg::MODE_ACK, 16'hFFFF, 1'b1, 8'h01),  // transfer done
      // cap above the hard limit, lowest sequence
      write_row(gbnws_pkg::CFG_WINDOW_CAP, 8'd63),
      write_row(gbnws_pkg::CFG_INITIAL_SEQUENCE, 8'h00),
      item_row(gbnws_pkg::MODE_START, 16'd40, 1'b0, 8'h00),
      item_row(gbnws_pkg::MODE_ACK, 16'd0, 1'b1, 8'h00),     // window grows to 2
      item_row(gbnws_pkg::MODE_ACK, 16'd0, 1'b1, 8'h01),     // partial ack
      item_row(gbnws_pkg::MODE_TIMEOUT, 16'd0, 1'b1, 8'h00), // partial ack dropped, rewind
      item_row(gbnws_pkg::MODE_ACK, 16'd0, 1'b1, 8'h01),
      item_row(gbnws_pkg::MODE_ACK, 16'd0, 1'b1, 8'h02),
      item_row(gbnws_pkg::MODE_ACK, 16'd0, 1'b1, 8'h03)
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_write) begin
        write_register(directed_plan[i].reg_index, directed_plan[i].reg_value);
      end else begin
        offer_item(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].result,
                   ignored);
      end
    end

    run_traffic(35);

    write_register(gbnws_pkg::CFG_INITIAL_SEQUENCE, 8'd250);
    write_register(gbnws_pkg::CFG_WINDOW_CAP, 8'd5);
    src_idle  = 51;
    sink_idle = 21;
    run_traffic(35);

    write_register(gbnws_pkg::CFG_INITIAL_SEQUENCE, 8'($urandom));
    write_register(gbnws_pkg::CFG_WINDOW_CAP, 8'd32);
    src_idle   = 0;
    sink_idle  = 0;
    hold_armed = 1'b1;
    run_traffic(35);

    // longest message, left open at the end
    write_register(gbnws_pkg::CFG_WINDOW_CAP, 8'd1);
    write_register(gbnws_pkg::CFG_INITIAL_SEQUENCE, 8'h80);
    offer_item({gbnws_pkg::MODE_START, 16'hFFFF, 1'b0, 8'h00}, 1'b0, '0, ignored);
    repeat (40) offer_item(random_item(), 1'b0, '0, ignored);

    settle(END_CYCLES);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== go_back_n_window_sender.f =====
rtl/core/gbnws_pkg.sv
rtl/core/gbnws_ctrl.sv
rtl/core/gbnws_dp.sv
rtl/core/go_back_n_window_sender.sv
rtl/core/gbnws_checker.sv
test/tb_go_back_n_window_sender.sv
